### hdl/dual_core_stop_edge_detector_core_macros.svh
// assertion helpers included by the top rtl file
`ifndef DUAL_CORE_STOP_EDGE_DETECTOR_CORE_MACROS_SVH
`define DUAL_CORE_STOP_EDGE_DETECTOR_CORE_MACROS_SVH

// condition must never hold outside reset
`define DSED_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// same-cycle implication
`define DSED_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dsed_pkg.sv
`timescale 1ns / 1ps

package dsed_pkg;

    localparam int unsigned CoreIdW   = 2;
    localparam int unsigned TickW     = 32;
    localparam int unsigned VerdictW  = 8;

    localparam logic [CoreIdW-1:0] CORE_A = 2'd0;
    localparam logic [CoreIdW-1:0] CORE_B = 2'd1;

    localparam logic [1:0] SEEN_NONE = 2'b00;
    localparam logic [1:0] SEEN_A    = 2'b01;
    localparam logic [1:0] SEEN_B    = 2'b10;
    localparam logic [1:0] SEEN_BOTH = 2'b11;

    typedef struct packed {
        logic [CoreIdW-1:0]  core_id;
        logic [TickW-1:0]    tick;
        logic [VerdictW-1:0] verdict;
    } report_t;

    typedef struct packed {
        logic press;
        logic mismatch;
    } result_t;

endpackage

### hdl/dual_core_stop_edge_detector_core.sv
`timescale 1ns / 1ps
//  channel  | signals                      | direction | moves
//  ---------+------------------------------+-----------+------------------------------
//  in       | in_valid in_ready            | sink      | item: core_id, tick, verdict
//  out      | out_valid out_ready          | source    | item: press, mismatch
//  cfg      | cfg_valid cfg_ready cfg_data | sink      | stop verdict code
//
//  one item per cycle sustained while the result side is not stalled; an accepted item
//  passes the input register, then evaluation, then the result register, where it shows valid
//  rst_n asynchronous, active low; clears stored ticks, verdicts, seen mask and edge history
//  a stalled result holds the result register, the input register still takes one more item
//  cfg is always ready; the stop code takes effect on the next evaluated item

module dual_core_stop_edge_detector_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dsed_pkg::CoreIdW-1:0]   core_id,
    input  logic [dsed_pkg::TickW-1:0]     tick,
    input  logic [dsed_pkg::VerdictW-1:0]  verdict,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           press,
    output logic                           mismatch,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsed_pkg::VerdictW-1:0]  cfg_data
);

`include "dual_core_stop_edge_detector_core_macros.svh"

    logic              held_valid;
    dsed_pkg::report_t held_item;
    dsed_pkg::result_t eval_result;
    logic              advance;

    logic out_valid_reg, out_valid_next;
    logic press_reg;
    logic mismatch_reg;

    // held item moves into the result register whenever that register is free or draining
    assign advance   = held_valid && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    dsed_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .core_id    (core_id),
        .tick       (tick),
        .verdict    (verdict),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // per-core state and edge history update only when the item is committed
    dsed_eval u_eval
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (held_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_code (cfg_data),
        .result   (eval_result)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded together with the valid flag
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            press_reg    <= eval_result.press;
            mismatch_reg <= eval_result.mismatch;
        end
    end

    assign out_valid = out_valid_reg;
    assign press     = press_reg;
    assign mismatch  = mismatch_reg;

    // both-stop and disagree are exclusive, so the two pulses never coincide
    `DSED_ASSERT_NEVER(a_excl_pulses, clk, rst_n, out_valid && press && mismatch, "press and mismatch together")
    // input stalls only when both stages are full and the result is blocked
    `DSED_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, held_valid && out_valid && !out_ready, "input stalled without cause")
    // a report from an unknown core yields an all-zero result
    `DSED_ASSERT_NEXT(a_bad_core_zero, clk, rst_n, advance && (held_item.core_id != dsed_pkg::CORE_A) && (held_item.core_id != dsed_pkg::CORE_B), out_valid && !press && !mismatch, "unknown core produced a pulse")

endmodule

### hdl/dsed_eval.sv
`timescale 1ns / 1ps

module dsed_eval
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  dsed_pkg::report_t              item,
    input  logic                           cfg_we,
    input  logic [dsed_pkg::VerdictW-1:0]  cfg_code,
    output dsed_pkg::result_t              result
);

    logic [dsed_pkg::TickW-1:0]    tick_a_reg, tick_a_next;
    logic [dsed_pkg::TickW-1:0]    tick_b_reg, tick_b_next;
    logic [dsed_pkg::VerdictW-1:0] verd_a_reg, verd_a_next;
    logic [dsed_pkg::VerdictW-1:0] verd_b_reg, verd_b_next;
    logic [1:0]                    seen_reg, seen_next;
    logic                          primed_reg, primed_next;
    logic                          both_reg, both_next;
    logic                          dis_reg, dis_next;
    logic [dsed_pkg::VerdictW-1:0] code_reg;

    logic is_a, is_b, complete, stop_a, stop_b, both, dis;

    always_comb
    begin
        is_a = (item.core_id == dsed_pkg::CORE_A);
        is_b = (item.core_id == dsed_pkg::CORE_B);

        tick_a_next = is_a ? item.tick : tick_a_reg;
        tick_b_next = is_b ? item.tick : tick_b_reg;
        verd_a_next = is_a ? item.verdict : verd_a_reg;
        verd_b_next = is_b ? item.verdict : verd_b_reg;
        seen_next   = seen_reg | (is_a ? dsed_pkg::SEEN_A : dsed_pkg::SEEN_NONE)
                               | (is_b ? dsed_pkg::SEEN_B : dsed_pkg::SEEN_NONE);

        complete = (is_a || is_b) && (seen_next == dsed_pkg::SEEN_BOTH)
                   && (tick_a_next == tick_b_next);
        stop_a   = (verd_a_next == code_reg);
        stop_b   = (verd_b_next == code_reg);
        both     = stop_a && stop_b;
        dis      = stop_a != stop_b;

        primed_next = primed_reg || complete;
        both_next   = complete ? both : both_reg;
        dis_next    = complete ? dis : dis_reg;

        result.press    = complete && primed_reg && both && !both_reg;
        result.mismatch = complete && primed_reg && dis && !dis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_a_reg <= '0;
            tick_b_reg <= '0;
            verd_a_reg <= '0;
            verd_b_reg <= '0;
            seen_reg   <= dsed_pkg::SEEN_NONE;
            primed_reg <= 1'b0;
            both_reg   <= 1'b0;
            dis_reg    <= 1'b0;
            code_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                tick_a_reg <= tick_a_next;
                tick_b_reg <= tick_b_next;
                verd_a_reg <= verd_a_next;
                verd_b_reg <= verd_b_next;
                seen_reg   <= seen_next;
                primed_reg <= primed_next;
                both_reg   <= both_next;
                dis_reg    <= dis_next;
            end
            if (cfg_we)
            begin
                code_reg <= cfg_code;
            end
        end
    end

endmodule

### hdl/dsed_in_stage.sv
`timescale 1ns / 1ps

module dsed_in_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dsed_pkg::CoreIdW-1:0]   core_id,
    input  logic [dsed_pkg::TickW-1:0]     tick,
    input  logic [dsed_pkg::VerdictW-1:0]  verdict,
    input  logic                           advance,
    output logic                           held_valid,
    output dsed_pkg::report_t              held_item
);

    logic              valid_reg, valid_next;
    dsed_pkg::report_t item_reg;

    // slot frees when its item moves on
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.core_id <= core_id;
            item_reg.tick    <= tick;
            item_reg.verdict <= verdict;
        end
    end

endmodule

### verif/dual_core_stop_edge_detector_core_test.sv
`timescale 1ns / 1ps

module dual_core_stop_edge_detector_core_test;

    localparam int unsigned CYCLE_LIMIT = 200000;
    // tail after the last result
    localparam int unsigned SETTLE_CYCLES = 4;

    // one line of the directed script: a report, or a new stop code when is_cfg is set
    typedef struct {
        bit                             is_cfg;
        logic [dsed_pkg::CoreIdW-1:0]   id;
        logic [dsed_pkg::TickW-1:0]     tk;
        logic [dsed_pkg::VerdictW-1:0]  vd;
        bit                             typed;
        bit                             p;
        bit                             m;
    } script_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [dsed_pkg::CoreIdW-1:0]   core_id = '0;
    logic [dsed_pkg::TickW-1:0]     tick = '0;
    logic [dsed_pkg::VerdictW-1:0]  verdict = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           press;
    logic                           mismatch;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dsed_pkg::VerdictW-1:0]  cfg_data = '0;

    // typed expectation travelling with the item on the input channel
    logic row_typed = 1'b0;
    logic row_press = 1'b0;
    logic row_mis = 1'b0;

    // shadow of the block state, reset values as declared
    logic [dsed_pkg::TickW-1:0]     shadow_tick [2] = '{default: '0};
    logic [dsed_pkg::VerdictW-1:0]  shadow_verdict [2] = '{default: '0};
    logic [1:0]                     shadow_seen = dsed_pkg::SEEN_NONE;
    logic                           shadow_primed = 1'b0;
    logic                           shadow_both_stop = 1'b0;
    logic                           shadow_disagree = 1'b0;
    logic [dsed_pkg::VerdictW-1:0]  shadow_stop_code = '0;

    dsed_pkg::result_t pending_flags [$];
    script_row_t       script [$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_pct = 30;
    int unsigned stall_pct = 30;
    int unsigned stall_left = 0;

    dual_core_stop_edge_detector_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .core_id   (core_id),
        .tick      (tick),
        .verdict   (verdict),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .press     (press),
        .mismatch  (mismatch),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // edge detection on the shadow state, one result per report
    function automatic dsed_pkg::result_t evaluate_report(
        input logic [dsed_pkg::CoreIdW-1:0]  id,
        input logic [dsed_pkg::TickW-1:0]    tk,
        input logic [dsed_pkg::VerdictW-1:0] vd
    );
        dsed_pkg::result_t flags;
        logic              stop_a;
        logic              stop_b;
        logic              both;
        logic              disagree;
        flags = '0;
        // ids above core b leave everything untouched
        if (id == dsed_pkg::CORE_A || id == dsed_pkg::CORE_B)
        begin
            shadow_tick[id[0]] = tk;
            shadow_verdict[id[0]] = vd;
            shadow_seen = shadow_seen |
                ((id == dsed_pkg::CORE_A) ? dsed_pkg::SEEN_A : dsed_pkg::SEEN_B);
            // compare only once both cores are known and stamped alike
            if (shadow_seen == dsed_pkg::SEEN_BOTH && shadow_tick[0] == shadow_tick[1])
            begin
                stop_a = (shadow_verdict[0] == shadow_stop_code);
                stop_b = (shadow_verdict[1] == shadow_stop_code);
                both = stop_a && stop_b;
                disagree = (stop_a != stop_b);
                // the first complete comparison only sets the baseline
                if (shadow_primed)
                begin
                    flags.press = both && !shadow_both_stop;
                    flags.mismatch = disagree && !shadow_disagree;
                end
                shadow_primed = 1'b1;
                shadow_both_stop = both;
                shadow_disagree = disagree;
            end
        end
        return flags;
    endfunction

    // watch all three handshakes on the edge, using pre-edge values
    always @(posedge clk)
    begin
        dsed_pkg::result_t predicted;
        dsed_pkg::result_t wanted;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time, pending_flags.size());
            $display("Some tests failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                shadow_stop_code = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                predicted = evaluate_report(core_id, tick, verdict);
                // directed rows may carry a hand-written answer instead
                if (row_typed)
                begin
                    predicted.press = row_press;
                    predicted.mismatch = row_mis;
                end
                pending_flags.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (pending_flags.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual press %b mismatch %b",
                             $time, press, mismatch);
                    fail_count++;
                end
                else
                begin
                    wanted = pending_flags.pop_front();
                    if (press !== wanted.press)
                    begin
                        $display("%0t press: expected %b, actual %b",
                                 $time, wanted.press, press);
                        fail_count++;
                    end
                    if (mismatch !== wanted.mismatch)
                    begin
                        $display("%0t mismatch: expected %b, actual %b",
                                 $time, wanted.mismatch, mismatch);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // present one item, maybe after a gap, and hold it until taken
    task automatic send_report(
        input logic [dsed_pkg::CoreIdW-1:0]  id,
        input logic [dsed_pkg::TickW-1:0]    tk,
        input logic [dsed_pkg::VerdictW-1:0] vd,
        input bit                            typed,
        input bit                            p,
        input bit                            m
    );
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        core_id <= id;
        tick <= tk;
        verdict <= vd;
        row_typed <= typed;
        row_press <= p;
        row_mis <= m;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_flags.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stop_code(input logic [dsed_pkg::VerdictW-1:0] code);
        cfg_valid <= 1'b1;
        cfg_data <= code;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(
        input bit                            is_cfg,
        input logic [dsed_pkg::CoreIdW-1:0]  id,
        input logic [dsed_pkg::TickW-1:0]    tk,
        input logic [dsed_pkg::VerdictW-1:0] vd,
        input bit                            typed,
        input bit                            p,
        input bit                            m
    );
        script_row_t row;
        row.is_cfg = is_cfg;
        row.id = id;
        row.tk = tk;
        row.vd = vd;
        row.typed = typed;
        row.p = p;
        row.m = m;
        script.push_back(row);
    endtask

    function automatic logic [dsed_pkg::VerdictW-1:0] draw_verdict(
        input logic [dsed_pkg::VerdictW-1:0] code
    );
        // lean towards the stop code so that edges happen often
        if ($urandom_range(0, 9) < 6)
        begin
            return code;
        end
        return dsed_pkg::VerdictW'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [dsed_pkg::TickW-1:0]     tick_base;
        logic [dsed_pkg::VerdictW-1:0]  code;
        logic [dsed_pkg::CoreIdW-1:0]   lead;
        int unsigned                    kind;

        // stop code is zero out of reset
        // ignored ids, both at field extremes
        add_row(0, 2'd2, 32'hFFFF_FFFF, 8'hFF, 1, 0, 0);
        add_row(0, 2'd3, 32'h0000_0000, 8'h00, 1, 0, 0);
        // core a alone, partner never seen
        add_row(0, dsed_pkg::CORE_A, 32'd5, 8'h00, 1, 0, 0);
        // core b with another tick, no comparison
        add_row(0, dsed_pkg::CORE_B, 32'd6, 8'h00, 1, 0, 0);
        // first complete comparison primes only
        add_row(0, dsed_pkg::CORE_B, 32'd5, 8'h00, 1, 0, 0);
        // both still stopping, no new edge
        add_row(0, dsed_pkg::CORE_A, 32'd5, 8'h00, 0, 0, 0);
        // core a leaves stop, disagreement rises
        add_row(0, dsed_pkg::CORE_A, 32'd5, 8'h01, 1, 0, 1);
        // core a back to stop, both stop rises
        add_row(0, dsed_pkg::CORE_A, 32'd5, 8'h00, 1, 1, 0);
        add_row(0, 2'd2, 32'd5, 8'h01, 1, 0, 0);
        add_row(0, dsed_pkg::CORE_B, 32'hFFFF_FFFF, 8'hFF, 1, 0, 0);
        add_row(0, dsed_pkg::CORE_A, 32'hFFFF_FFFF, 8'hFF, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_A, 32'hFFFF_FFFF, 8'h00, 1, 0, 1);
        add_row(0, dsed_pkg::CORE_B, 32'hFFFF_FFFF, 8'h00, 1, 1, 0);
        // stop code at its top value
        add_row(1, 2'd0, 32'd0, 8'hFF, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_A, 32'd0, 8'hFF, 1, 0, 0);
        add_row(0, dsed_pkg::CORE_B, 32'd0, 8'hFF, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_B, 32'd0, 8'h80, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_A, 32'd0, 8'h80, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_A, 32'd0, 8'hFF, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_B, 32'd0, 8'hFF, 0, 0, 0);
        // back to a zero stop code, then both cores report zero verdicts
        add_row(1, 2'd0, 32'd0, 8'h00, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_A, 32'd0, 8'h00, 0, 0, 0);
        add_row(0, dsed_pkg::CORE_B, 32'd0, 8'h00, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                wait_drained();
                write_stop_code(script[i].vd);
            end
            else
            begin
                send_report(script[i].id, script[i].tk, script[i].vd,
                            script[i].typed, script[i].p, script[i].m);
            end
        end

        // random phases, one stop code each, the last one without idling
        tick_base = $urandom;
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            case (ph)
                0: code = 8'h00;
                1: code = 8'hFF;
                default: code = dsed_pkg::VerdictW'($urandom_range(0, 255));
            endcase
            write_stop_code(code);
            gap_pct = (ph == 2 || ph == 7) ? 0 : $urandom_range(10, 40);
            stall_pct = (ph == 3 || ph == 7) ? 0 : $urandom_range(10, 40);
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    tick_base = $urandom;
                end
                else
                begin
                    tick_base = tick_base + $urandom_range(0, 2);
                end
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    // well-formed pair: both cores report the same tick
                    lead = dsed_pkg::CoreIdW'($urandom_range(0, 1));
                    send_report(lead, tick_base, draw_verdict(code), 0, 0, 0);
                    send_report(lead ^ 2'd1, tick_base, draw_verdict(code), 0, 0, 0);
                end
                else if (kind == 7)
                begin
                    // noise on an id that is ignored
                    send_report(2'd2 | 2'($urandom_range(0, 1)), $urandom,
                                dsed_pkg::VerdictW'($urandom_range(0, 255)), 0, 0, 0);
                end
                else if (kind == 8)
                begin
                    // lone update at the current tick
                    send_report(dsed_pkg::CoreIdW'($urandom_range(0, 1)), tick_base,
                                draw_verdict(code), 0, 0, 0);
                end
                else
                begin
                    // broken pair, stamp out of step
                    send_report(dsed_pkg::CoreIdW'($urandom_range(0, 1)), $urandom,
                                draw_verdict(code), 0, 0, 0);
                end
            end
        end

        wait_drained();
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/dsed_pkg.sv
hdl/dsed_eval.sv
hdl/dsed_in_stage.sv
hdl/dual_core_stop_edge_detector_core.sv
verif/dual_core_stop_edge_detector_core_test.sv
